### src/krt_pkg.sv
// shared types, constants and helpers for the keyed record table
package krt_pkg;

    // field widths fixed by the command and result formats
    localparam int KEY_W        = 32;
    localparam int PAYLOAD_W    = 64;
    localparam int COUNT_OUT_W  = 7;
    localparam int KIND_W       = 2;
    localparam int IN_DATA_W    = KEY_W + PAYLOAD_W;
    localparam int OUT_DATA_W   = 1 + PAYLOAD_W + COUNT_OUT_W;

    // default table geometry
    localparam int DEF_ENTRIES       = 64;
    localparam int DEF_PAYLOAD_BYTES = 8;

    // command codes
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_REMOVE = 2'd3
    } kind_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear_wr;   // write an empty entry at the sweep address
        logic capture;    // take in the accepted item
        logic scan_rd;    // read the key store at the sweep address
        logic act;        // apply the operation to the chosen slot
        logic load_out;   // move the result into the output register
    } krt_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_busy;   // output register holds an item not yet taken
    } krt_status_t;

    // keep up to nbytes name bytes, stopping at the first zero byte
    function automatic logic [PAYLOAD_W-1:0] clip_name(input logic [PAYLOAD_W-1:0] raw,
                                                      input int nbytes);
        logic [PAYLOAD_W-1:0] r;
        logic                 live;
        r    = '0;
        live = 1'b1;
        for (int b = 0; b < PAYLOAD_W / 8; b++)
        begin
            if (b >= nbytes || raw[8*b +: 8] == 8'd0)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                r[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return r;
    endfunction

endpackage

### src/krt_ctrl.sv
// sequencer for the keyed record table: clearing sweep, key scan, update, result
module krt_ctrl #(
    parameter int ENTRIES = krt_pkg::DEF_ENTRIES,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output krt_pkg::krt_cmd_t    cmd,
    input  krt_pkg::krt_status_t status,
    output logic [IDX_W-1:0]     addr
);
    import krt_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_LAST   = 6'b001000,
        ST_ACT    = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    addr_next   = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = ST_LAST;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_LAST:
            begin
                // compare of the last entry completes here
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                cmd.act    = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    assign addr = addr_reg;

endmodule

### src/krt_datapath.sv
// key and payload stores, scan compare, count and output register
module krt_datapath #(
    parameter int ENTRIES       = krt_pkg::DEF_ENTRIES,
    parameter int PAYLOAD_BYTES = krt_pkg::DEF_PAYLOAD_BYTES,
    parameter int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  krt_pkg::krt_cmd_t                cmd,
    output krt_pkg::krt_status_t             status,
    input  logic [IDX_W-1:0]                 addr,
    input  logic [krt_pkg::KIND_W-1:0]       kind,
    input  logic [krt_pkg::KEY_W-1:0]        key,
    input  logic [krt_pkg::PAYLOAD_W-1:0]    payload_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             success,
    output logic [krt_pkg::PAYLOAD_W-1:0]    payload_out,
    output logic [krt_pkg::COUNT_OUT_W-1:0]  occupied_count
);
    import krt_pkg::*;

    localparam int PAY_W   = 8 * PAYLOAD_BYTES;
    localparam int COUNT_W = $clog2(ENTRIES + 1);

    // stores: key entry carries its valid mark in the top bit
    logic [KEY_W:0]     key_mem [ENTRIES];
    logic [PAY_W-1:0]   pay_mem [ENTRIES];

    // captured item
    kind_t              kind_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [PAY_W-1:0]   pay_reg;

    // scan results
    logic [KEY_W:0]     key_rd_reg;
    logic               rd_ok_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   found_idx_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    // operation outcome
    logic               ok_reg;
    logic [PAY_W-1:0]   pay_rd_reg;
    logic [COUNT_W-1:0] count_reg;

    // output register
    logic                   out_valid_reg;
    logic                   out_success_reg;
    logic [PAYLOAD_W-1:0]   out_payload_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;

    logic                   insert_ok;
    logic                   act_ok;
    logic                   key_we;
    logic [IDX_W-1:0]       key_waddr;
    logic [KEY_W:0]         key_wdata;
    logic                   pay_we;
    logic [IDX_W-1:0]       pay_waddr;
    logic [COUNT_W+COUNT_OUT_W-1:0] count_ext;

    // decide the outcome from the finished scan
    assign insert_ok = (kind_reg == KIND_INSERT) && !found_reg && free_reg;
    assign act_ok    = insert_ok || ((kind_reg != KIND_INSERT) && found_reg);

    // key store write port
    always_comb
    begin
        key_we    = 1'b0;
        key_waddr = addr;
        key_wdata = '0;
        if (cmd.clear_wr)
        begin
            key_we = 1'b1;
        end
        else if (cmd.act && insert_ok)
        begin
            key_we    = 1'b1;
            key_waddr = free_idx_reg;
            key_wdata = {1'b1, key_reg};
        end
        else if (cmd.act && act_ok && kind_reg == KIND_REMOVE)
        begin
            key_we    = 1'b1;
            key_waddr = found_idx_reg;
            key_wdata = {1'b0, key_reg};
        end
    end

    // payload store write port
    always_comb
    begin
        pay_we    = 1'b0;
        pay_waddr = found_idx_reg;
        if (cmd.act && insert_ok)
        begin
            pay_we    = 1'b1;
            pay_waddr = free_idx_reg;
        end
        else if (cmd.act && act_ok && kind_reg == KIND_UPDATE)
        begin
            pay_we = 1'b1;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        if (cmd.scan_rd)
        begin
            key_rd_reg <= key_mem[addr];
        end
        if (pay_we)
        begin
            pay_mem[pay_waddr] <= pay_reg;
        end
        if (cmd.act)
        begin
            pay_rd_reg <= pay_mem[found_idx_reg];
        end
    end

    // payload registers: captured item and scan indexes
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(kind);
            key_reg  <= key;
            pay_reg  <= PAY_W'(clip_name(payload_in, PAYLOAD_BYTES));
        end
        rd_idx_reg <= addr;
        if (rd_ok_reg && key_rd_reg[KEY_W] && key_rd_reg[KEY_W-1:0] == key_reg && !found_reg)
        begin
            found_idx_reg <= rd_idx_reg;
        end
        if (rd_ok_reg && !key_rd_reg[KEY_W] && !free_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.act)
        begin
            ok_reg <= act_ok;
        end
    end

    assign count_ext = (COUNT_W + COUNT_OUT_W)'(count_reg);

    // control registers: scan flags, count, output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg     <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= cmd.scan_rd;
            if (cmd.capture)
            begin
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            else if (rd_ok_reg)
            begin
                if (key_rd_reg[KEY_W] && key_rd_reg[KEY_W-1:0] == key_reg)
                begin
                    found_reg <= 1'b1;
                end
                if (!key_rd_reg[KEY_W])
                begin
                    free_reg <= 1'b1;
                end
            end
            if (cmd.act && insert_ok)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.act && act_ok && kind_reg == KIND_REMOVE && count_reg != '0)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_success_reg <= ok_reg;
            out_payload_reg <= (kind_reg == KIND_LOOKUP && ok_reg) ?
                               PAYLOAD_W'(pay_rd_reg) : '0;
            out_count_reg   <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign success         = out_success_reg;
    assign payload_out     = out_payload_reg;
    assign occupied_count  = out_count_reg;

endmodule

### src/keyed_record_table.sv
// top level of the keyed record table: stream ports, sequencer and datapath
//
//  channel   | direction | tdata (low bit up)                        | tuser
//  ----------+-----------+-------------------------------------------+------------
//  s_axis    | in        | key[31:0], payload_in[63:0]               | kind[1:0]
//  m_axis    | out       | success, payload_out[63:0], occupied_count | none
//
//  after acceptance an item is handled in these steps: a scan read of the key store for
//  each slot, then the compare of the last entry, the update of the chosen slot and the
//  result load; the next item is taken in the idle state that follows the result load.
//  after reset a clearing sweep writes every key entry empty, with s_axis_tready low.
//  one item is in work at a time; the result waits in an output register, and a stalled
//  m_axis holds the next result in the final step.
module keyed_record_table #(
    parameter int ENTRIES       = krt_pkg::DEF_ENTRIES,
    parameter int PAYLOAD_BYTES = krt_pkg::DEF_PAYLOAD_BYTES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [krt_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // key, payload_in
    input  logic [krt_pkg::KIND_W-1:0]        s_axis_tuser,   // kind
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [krt_pkg::OUT_DATA_W-1:0]    m_axis_tdata    // success, payload_out, occupied_count
);
    import krt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    krt_cmd_t               cmd;
    krt_status_t            status;
    logic [IDX_W-1:0]       addr;
    logic                   success;
    logic [PAYLOAD_W-1:0]   payload_out;
    logic [COUNT_OUT_W-1:0] occupied_count;

    // sequencer
    krt_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .status   (status),
        .addr     (addr)
    );

    // stores and result path
    krt_datapath #(
        .ENTRIES       (ENTRIES),
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .IDX_W         (IDX_W)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .addr           (addr),
        .kind           (s_axis_tuser),
        .key            (s_axis_tdata[KEY_W-1:0]),
        .payload_in     (s_axis_tdata[KEY_W +: PAYLOAD_W]),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .success        (success),
        .payload_out    (payload_out),
        .occupied_count (occupied_count)
    );

    // pack result fields
    assign m_axis_tdata = {occupied_count, payload_out, success};

endmodule

### tb/keyed_record_table_tb.sv
// stream-level testbench for the keyed record table with a self-checking table predictor
module keyed_record_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import krt_pkg::*;

    localparam int ENTRIES      = DEF_ENTRIES;
    localparam int NAME_BYTES   = DEF_PAYLOAD_BYTES;
    localparam int RANDOM_ITEMS = 1000;
    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 500;

    typedef struct {
        kind_t                kind;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        bit                   settle;    // wait for every reply before offering
    } table_cmd_t;

    typedef struct {
        kind_t                  kind;
        logic [KEY_W-1:0]       key;
        logic                   success;
        logic [PAYLOAD_W-1:0]   payload;
        logic [COUNT_OUT_W-1:0] count;
    } table_reply_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // key, payload_in
    logic [KIND_W-1:0]     s_axis_tuser = '0;   // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // success, payload_out, occupied_count

    // commands waiting to be offered and replies waiting to arrive
    table_cmd_t   cmd_queue[$];
    table_reply_t predicted_replies[$];

    // key set as the command stream leaves it, used to shape the stimulus
    logic [KEY_W-1:0] gen_live[$];
    logic [KEY_W-1:0] gen_gone[$];

    // predicted table contents
    bit                   tbl_valid[ENTRIES];
    logic [KEY_W-1:0]     tbl_key[ENTRIES];
    logic [PAYLOAD_W-1:0] tbl_payload[ENTRIES];
    int                   tbl_count = 0;
    int                   tbl_peak = 0;

    // run statistics
    int kind_total[4] = '{default: 0};
    int kind_ok[4] = '{default: 0};
    int full_refusals = 0;
    int dup_refusals = 0;
    int replies_checked = 0;
    int errors = 0;

    // handshake state shared between the sampling and driving processes
    bit in_fire = 1'b0;
    bit out_fire = 1'b0;
    bit drv_offer = 1'b0;
    bit drv_quiet = 1'b0;
    int drv_gap = -1;
    int sent_items = 0;
    bit rcv_ready = 1'b0;
    bit rcv_quiet = 1'b0;
    int rcv_gap = 0;
    int rcv_hold = 0;
    int taken_replies = 0;

    keyed_record_table #(
        .ENTRIES       (ENTRIES),
        .PAYLOAD_BYTES (NAME_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // name bytes kept in the table: up to NAME_BYTES, cut at the first zero byte
    function automatic logic [PAYLOAD_W-1:0] name_keep(logic [PAYLOAD_W-1:0] raw);
        logic [PAYLOAD_W-1:0] r;
        bit                   ended;
        r     = '0;
        ended = 1'b0;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (raw[8*b +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                r[8*b +: 8] = raw[8*b +: 8];
        end
        return r;
    endfunction

    // apply one command to the predicted table and return the reply it yields
    function automatic table_reply_t table_apply(kind_t kind, logic [KEY_W-1:0] key,
                                                 logic [PAYLOAD_W-1:0] raw);
        table_reply_t r;
        int           hit;
        int           free_slot;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tbl_valid[i] && tbl_key[i] == key && hit < 0)
                hit = i;
            if (!tbl_valid[i] && free_slot < 0)
                free_slot = i;
        end
        r.kind    = kind;
        r.key     = key;
        r.success = 1'b0;
        r.payload = '0;
        case (kind)
            KIND_INSERT:
            begin
                if (hit >= 0)
                    dup_refusals++;
                else if (free_slot < 0)
                    full_refusals++;
                else
                begin
                    tbl_valid[free_slot]   = 1'b1;
                    tbl_key[free_slot]     = key;
                    tbl_payload[free_slot] = name_keep(raw);
                    tbl_count++;
                    r.success = 1'b1;
                end
            end
            KIND_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    r.payload = tbl_payload[hit];
                    r.success = 1'b1;
                end
            end
            KIND_UPDATE:
            begin
                if (hit >= 0)
                begin
                    tbl_payload[hit] = name_keep(raw);
                    r.success = 1'b1;
                end
            end
            default:
            begin
                if (hit >= 0)
                begin
                    tbl_valid[hit] = 1'b0;
                    tbl_count--;
                    r.success = 1'b1;
                end
            end
        endcase
        if (tbl_count > tbl_peak)
            tbl_peak = tbl_count;
        r.count = tbl_count[COUNT_OUT_W-1:0];
        kind_total[kind]++;
        if (r.success)
            kind_ok[kind]++;
        return r;
    endfunction

    // compare one reply field and report a mismatch
    function automatic void field_check(string field, table_reply_t want,
                                        logic [PAYLOAD_W-1:0] exp_val,
                                        logic [PAYLOAD_W-1:0] got_val);
        if (exp_val !== got_val)
        begin
            $display("%0t: %s mismatch on %s key %h: expected %h, got %h",
                     $time, field, want.kind.name(), want.key, exp_val, got_val);
            errors++;
        end
    endfunction

    // position of a key in the stimulus key set, -1 if absent
    function automatic int live_pos(logic [KEY_W-1:0] key);
        for (int i = 0; i < gen_live.size(); i++)
        begin
            if (gen_live[i] == key)
                return i;
        end
        return -1;
    endfunction

    // queue one command and track the key set it leaves behind
    function automatic void queue_cmd(kind_t kind, logic [KEY_W-1:0] key,
                                      logic [PAYLOAD_W-1:0] payload);
        table_cmd_t c;
        int         pos;
        pos        = live_pos(key);
        c.kind     = kind;
        c.key      = key;
        c.payload  = payload;
        c.settle   = 1'b0;
        cmd_queue.push_back(c);
        if (kind == KIND_INSERT && pos < 0 && gen_live.size() < ENTRIES)
            gen_live.push_back(key);
        else if (kind == KIND_REMOVE && pos >= 0)
        begin
            gen_live.delete(pos);
            gen_gone.push_back(key);
            if (gen_gone.size() > 16)
                void'(gen_gone.pop_front());
        end
    endfunction

    // random name word, often cut short by a zero byte
    function automatic logic [PAYLOAD_W-1:0] random_name();
        logic [PAYLOAD_W-1:0] n;
        int                   r;
        n = {$urandom, $urandom};
        r = $urandom_range(0, 9);
        if (r == 0)
            n = '0;
        else if (r < 4)
            n[8*$urandom_range(0, 7) +: 8] = 8'h00;
        return n;
    endfunction

    // key not present in the table, often a small signed value
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 31) - 32'd16 : $urandom;
        while (live_pos(k) >= 0)
            k = $urandom;
        return k;
    endfunction

    // key biased toward present and recently removed records
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6 && gen_live.size() > 0)
            return gen_live[$urandom_range(0, gen_live.size() - 1)];
        if (r < 8 && gen_gone.size() > 0)
            return gen_gone[$urandom_range(0, gen_gone.size() - 1)];
        return fresh_key();
    endfunction

    // sample handshakes, predict accepted commands and check replies
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    $display("%0t: reply with no command pending: expected none, got %h",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    table_reply_t want;
                    want = predicted_replies.pop_front();
                    field_check("success", want, 64'(want.success), 64'(m_axis_tdata[0]));
                    field_check("payload_out", want, want.payload,
                                m_axis_tdata[PAYLOAD_W:1]);
                    field_check("occupied_count", want, 64'(want.count),
                                64'(m_axis_tdata[OUT_DATA_W-1:PAYLOAD_W+1]));
                    replies_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predicted_replies.push_back(table_apply(kind_t'(s_axis_tuser),
                                                        s_axis_tdata[KEY_W-1:0],
                                                        s_axis_tdata[IN_DATA_W-1:KEY_W]));
            in_fire  <= s_axis_tvalid && s_axis_tready;
            out_fire <= m_axis_tvalid && m_axis_tready;
        end
    end

    // command driver: random gaps, optional settle before an item
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (drv_offer && in_fire)
            begin
                drv_offer = 1'b0;
                sent_items++;
                if (sent_items % 40 == 0)
                    drv_quiet = ($urandom_range(0, 2) == 0);
            end
            if (!drv_offer && cmd_queue.size() > 0)
            begin
                if (drv_gap < 0)
                    drv_gap = drv_quiet ? 0 : $urandom_range(0, 10);
                if (!(cmd_queue[0].settle && predicted_replies.size() > 0))
                begin
                    if (drv_gap > 0)
                        drv_gap--;
                    else
                    begin
                        table_cmd_t c;
                        c = cmd_queue.pop_front();
                        s_axis_tdata <= {c.payload, c.key};
                        s_axis_tuser <= c.kind;
                        drv_offer = 1'b1;
                        drv_gap   = -1;
                    end
                end
            end
            s_axis_tvalid <= drv_offer;
        end
    end

    // reply receiver: random stalls plus two long hold-offs
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
            begin
                taken_replies++;
                if (taken_replies % 40 == 0)
                    rcv_quiet = ($urandom_range(0, 2) == 0);
                rcv_gap = rcv_quiet ? 0 : $urandom_range(0, 10);
                if (taken_replies == 300 || taken_replies == 750)
                    rcv_hold = LONG_HOLD;
            end
            if (rcv_hold > 0)
            begin
                rcv_hold--;
                rcv_ready = 1'b0;
            end
            else if (rcv_gap > 0)
            begin
                rcv_gap--;
                rcv_ready = 1'b0;
            end
            else
                rcv_ready = 1'b1;
            m_axis_tready <= rcv_ready;
        end
    end

    // run limit
    initial
    begin
        int cyc;
        for (cyc = 0; cyc < LIMIT_CYCLES; cyc++)
            @(posedge clk);
        $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
        $display("Verification failed");
        $finish;
    end

    // stimulus, reset and end of run
    initial
    begin
        int ep;
        int n;
        int target;
        int first;
        int r;

        // directed: empty-table misses, extreme keys, name clipping, reuse of a freed slot
        queue_cmd(KIND_LOOKUP, 32'h0000_0000, 64'h0);
        queue_cmd(KIND_REMOVE, 32'h0000_0000, 64'h0);
        queue_cmd(KIND_UPDATE, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_cmd(KIND_INSERT, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_cmd(KIND_INSERT, 32'h7FFF_FFFF, 64'h1122_3344_0055_6677);
        queue_cmd(KIND_INSERT, 32'h0000_0000, 64'h0);
        queue_cmd(KIND_INSERT, 32'hFFFF_FFFF, 64'h0000_0000_0000_0001);
        queue_cmd(KIND_INSERT, 32'h8000_0000, 64'h0102_0304_0506_0708);
        queue_cmd(KIND_INSERT, 32'h0000_0001, 64'hFFFF_FFFF_FFFF_FF00);
        queue_cmd(KIND_LOOKUP, 32'h8000_0000, 64'h0);
        queue_cmd(KIND_LOOKUP, 32'h7FFF_FFFF, 64'h0);
        queue_cmd(KIND_LOOKUP, 32'h0000_0000, 64'h0);
        queue_cmd(KIND_LOOKUP, 32'hFFFF_FFFF, 64'h0);
        queue_cmd(KIND_LOOKUP, 32'h0000_0001, 64'h0);
        queue_cmd(KIND_UPDATE, 32'h7FFF_FFFF, 64'hFEDC_BA98_7654_3210);
        queue_cmd(KIND_LOOKUP, 32'h7FFF_FFFF, 64'h0);
        queue_cmd(KIND_LOOKUP, 32'h7FFF_FFFE, 64'h0);
        queue_cmd(KIND_REMOVE, 32'h8000_0000, 64'h0);
        queue_cmd(KIND_LOOKUP, 32'h8000_0000, 64'h0);
        queue_cmd(KIND_REMOVE, 32'h8000_0000, 64'h0);
        queue_cmd(KIND_UPDATE, 32'h8000_0000, 64'h5555_5555_5555_5555);
        queue_cmd(KIND_INSERT, 32'h8000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_cmd(KIND_LOOKUP, 32'h8000_0000, 64'h0);

        // random episodes: fill to full, drain, mixed traffic and noise
        ep = 0;
        while (cmd_queue.size() < RANDOM_ITEMS + 23)
        begin
            first = cmd_queue.size();
            r = (ep == 0) ? 0 : $urandom_range(0, 9);
            if (r < 2)
            begin
                while (gen_live.size() < ENTRIES)
                begin
                    if ($urandom_range(0, 3) == 0)
                        queue_cmd(KIND_LOOKUP, pick_key(), random_name());
                    queue_cmd(KIND_INSERT, fresh_key(), random_name());
                end
                n = $urandom_range(1, 3);
                repeat (n)
                    queue_cmd(KIND_INSERT, fresh_key(), random_name());
                queue_cmd(KIND_INSERT, gen_live[$urandom_range(0, ENTRIES - 1)], random_name());
                queue_cmd(KIND_UPDATE, gen_live[$urandom_range(0, ENTRIES - 1)], random_name());
            end
            else if (r < 4)
            begin
                target = $urandom_range(0, 8);
                while (gen_live.size() > target)
                begin
                    queue_cmd(KIND_REMOVE, gen_live[$urandom_range(0, gen_live.size() - 1)],
                              random_name());
                    if ($urandom_range(0, 3) == 0)
                        queue_cmd(KIND_LOOKUP, pick_key(), random_name());
                end
            end
            else if (r < 9)
            begin
                n = $urandom_range(20, 60);
                repeat (n)
                begin
                    kind_t k;
                    k = kind_t'($urandom_range(0, 3));
                    if (k == KIND_INSERT && $urandom_range(0, 1) == 0)
                        queue_cmd(k, fresh_key(), random_name());
                    else
                        queue_cmd(k, pick_key(), random_name());
                end
            end
            else
            begin
                n = $urandom_range(5, 15);
                repeat (n)
                    queue_cmd(kind_t'($urandom_range(0, 3)), $urandom, {$urandom, $urandom});
            end
            if (ep % 6 == 0 && cmd_queue.size() > first)
                cmd_queue[first].settle = 1'b1;
            ep++;
        end

        // reset
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for every command to be answered, then let the block go quiet
        while (cmd_queue.size() > 0 || s_axis_tvalid || predicted_replies.size() > 0)
            @(posedge clk);
        repeat (ENTRIES + 20) @(posedge clk);

        $display("checked %0d replies: insert %0d/%0d, lookup %0d/%0d, update %0d/%0d, remove %0d/%0d succeeded",
                 replies_checked, kind_ok[KIND_INSERT], kind_total[KIND_INSERT],
                 kind_ok[KIND_LOOKUP], kind_total[KIND_LOOKUP],
                 kind_ok[KIND_UPDATE], kind_total[KIND_UPDATE],
                 kind_ok[KIND_REMOVE], kind_total[KIND_REMOVE]);
        $display("inserts refused: %0d on a full table, %0d on a duplicate key; peak %0d records",
                 full_refusals, dup_refusals, tbl_peak);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
src/krt_pkg.sv
src/krt_ctrl.sv
src/krt_datapath.sv
src/keyed_record_table.sv
tb/keyed_record_table_tb.sv
